// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  `ASSERT_PROP(label, clk, rst, (ante) |-> (cons))

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  `ASSERT_PROP(label, clk, rst, (ante) |=> (cons))

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types and constants of the serial bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int MAP_W    = 18;
  localparam int MIR_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  // Bus access kind
  typedef enum logic [1:0] {
    FUNC_CPU_RD = 2'd0,
    FUNC_CPU_WR = 2'd1,
    FUNC_PIC_RD = 2'd2,
    FUNC_PIC_WR = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_COUNT = 2'd1;

  // Commit targets, picked by address bits 14:13
  localparam logic [1:0] TGT_CONTROL  = 2'd0;
  localparam logic [1:0] TGT_CHAR_LOW = 2'd1;
  localparam logic [1:0] TGT_CHAR_HIGH = 2'd2;
  localparam logic [1:0] TGT_PROG     = 2'd3;

  // Program modes, control bits 3:2
  localparam logic [1:0] MODE_FIXED_FIRST = 2'd2;
  localparam logic [1:0] MODE_FIXED_LAST  = 2'd3;

  // Reset values and fixed numbers
  localparam logic [4:0] CONTROL_RESET    = 5'h1C;
  localparam logic [4:0] CONTROL_PROG_FIX = 5'h0C;
  localparam logic [1:0] MIRROR_RESET     = 2'd3;
  localparam logic [4:0] PROG_COUNT_RESET = 5'd16;
  localparam logic [5:0] CHAR_COUNT_RESET = 6'd0;
  localparam logic [2:0] SHIFT_LAST       = 3'd4;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_data;
  } access_t;

  typedef struct packed {
    logic             handled;
    logic [MAP_W-1:0] mapped_address;
    logic [MIR_W-1:0] mirroring;
  } result_t;

endpackage

// ----- rtl/sbsm_xlate.sv -----
// ----------------------------------------------------------------------------
// sbsm_xlate
// Mapper state and the single-pass translation of one bus access.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbsm_xlate (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  sbsm_pkg::access_t access,
  input  logic [4:0]      prog_count,
  input  logic [5:0]      char_count,
  output sbsm_pkg::result_t result
);
  import sbsm_pkg::*;

  logic [4:0] shift_value, shift_value_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_word, control_word_next;
  logic [4:0] char_low_bank, char_low_bank_next;
  logic [4:0] char_high_bank, char_high_bank_next;
  logic [4:0] char_pair_bank, char_pair_bank_next;
  logic [3:0] prog_half_bank, prog_half_bank_next;
  logic [2:0] prog_full_bank, prog_full_bank_next;
  logic [1:0] mirror_state, mirror_state_next;

  logic [ADDR_W-1:0] a;
  logic [DATA_W-1:0] d;
  logic              four_k;
  logic [1:0]        mode;
  logic [4:0]        shifted;
  logic [4:0]        last_full;
  logic [3:0]        last_bank;
  logic [MAP_W-1:0]  prog_addr;
  logic [MAP_W-1:0]  char_addr;
  logic              is_commit;
  logic              is_reset_wr;

  assign a         = access.bus_address;
  assign d         = access.write_data;
  assign four_k    = control_word[4];
  assign mode      = control_word[3:2];
  assign shifted   = {d[0], shift_value[4:1]};
  assign last_full = prog_count - 5'd1;
  assign last_bank = last_full[3:0];
  assign is_commit = fire && (access.func == FUNC_CPU_WR) && a[15] && !d[7]
                     && (shift_count == SHIFT_LAST);
  assign is_reset_wr = fire && (access.func == FUNC_CPU_WR) && a[15] && d[7];

  // Program window translation
  always_comb begin
    case (mode)
      MODE_FIXED_FIRST: begin
        prog_addr = a[14] ? {prog_half_bank, a[13:0]} : {4'd0, a[13:0]};
      end
      MODE_FIXED_LAST: begin
        prog_addr = a[14] ? {last_bank, a[13:0]} : {prog_half_bank, a[13:0]};
      end
      default: begin
        prog_addr = {prog_full_bank, a[14:0]};
      end
    endcase
  end

  // Character window translation
  always_comb begin
    if (char_count == 6'd0) begin
      char_addr = {2'd0, a};
    end else if (four_k) begin
      char_addr = {1'b0, (a[12] ? char_high_bank : char_low_bank), a[11:0]};
    end else begin
      char_addr = {1'b0, char_pair_bank, 12'd0} + {5'd0, a[12:0]};
    end
  end

  // Decode the access, update the serial register and commit
  always_comb begin
    shift_value_next    = shift_value;
    shift_count_next    = shift_count;
    control_word_next   = control_word;
    char_low_bank_next  = char_low_bank;
    char_high_bank_next = char_high_bank;
    char_pair_bank_next = char_pair_bank;
    prog_half_bank_next = prog_half_bank;
    prog_full_bank_next = prog_full_bank;
    mirror_state_next   = mirror_state;
    result.handled        = 1'b0;
    result.mapped_address = '0;

    case (access.func)
      FUNC_CPU_RD: begin
        if (a[15]) begin
          result.handled        = 1'b1;
          result.mapped_address = prog_addr;
        end
      end
      FUNC_CPU_WR: begin
        if (a[15]) begin
          result.handled = 1'b1;
          if (fire) begin
            if (d[7]) begin
              shift_value_next  = 5'd0;
              shift_count_next  = 3'd0;
              control_word_next = control_word | CONTROL_PROG_FIX;
            end else if (shift_count == SHIFT_LAST) begin
              shift_value_next = 5'd0;
              shift_count_next = 3'd0;
              case (a[14:13])
                TGT_CONTROL: begin
                  control_word_next = shifted;
                  mirror_state_next = shifted[1:0];
                end
                TGT_CHAR_LOW: begin
                  if (four_k) char_low_bank_next = shifted;
                  else        char_pair_bank_next = {shifted[4:1], 1'b0};
                end
                TGT_CHAR_HIGH: begin
                  if (four_k) char_high_bank_next = shifted;
                end
                default: begin
                  if (!mode[1]) prog_full_bank_next = shifted[3:1];
                  else          prog_half_bank_next = shifted[3:0];
                end
              endcase
            end else begin
              shift_value_next = shifted;
              shift_count_next = shift_count + 3'd1;
            end
          end
        end
      end
      FUNC_PIC_RD: begin
        if (a[15:13] == 3'd0) begin
          result.handled        = 1'b1;
          result.mapped_address = char_addr;
        end
      end
      default: begin
        if ((a[15:13] == 3'd0) && (char_count == 6'd0)) begin
          result.handled        = 1'b1;
          result.mapped_address = {2'd0, a};
        end
      end
    endcase

    result.mirroring = mirror_state_next;
  end

  // Hold mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value    <= 5'd0;
      shift_count    <= 3'd0;
      control_word   <= CONTROL_RESET;
      char_low_bank  <= 5'd0;
      char_high_bank <= 5'd0;
      char_pair_bank <= 5'd0;
      prog_half_bank <= 4'd0;
      prog_full_bank <= 3'd0;
      mirror_state   <= MIRROR_RESET;
    end else begin
      shift_value    <= shift_value_next;
      shift_count    <= shift_count_next;
      control_word   <= control_word_next;
      char_low_bank  <= char_low_bank_next;
      char_high_bank <= char_high_bank_next;
      char_pair_bank <= char_pair_bank_next;
      prog_half_bank <= prog_half_bank_next;
      prog_full_bank <= prog_full_bank_next;
      mirror_state   <= mirror_state_next;
    end
  end

  `ASSERT_PROP(a_shift_count_range, clk, rst, shift_count <= SHIFT_LAST)
  `ASSERT_NEXT(a_commit_clears_shift, clk, rst, is_commit, shift_count == 3'd0)
  `ASSERT_NEXT(a_reset_write_mode, clk, rst, is_reset_wr, control_word[3:2] == MODE_FIXED_LAST)

endmodule

// ----- rtl/serial_bank_switch_mapper_core.sv -----
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core
// Bank-switching cartridge address mapper with a serial register load port.
// ----------------------------------------------------------------------------
// Each input word is one bus access (kind on s_tuser, address and write data
// on s_tdata); each produces exactly one output word carrying the handled flag
// on m_tuser and the mapped address plus mirroring mode on m_tdata.
// A word is taken into an input register, translated by one level of logic
// and written to a result register, which drives m_tvalid. One access per
// clock is sustained while m_tready stays high; the limit is the single
// update of the serial register and bank registers per cycle. The user must
// write the bank counts on the cfg port only while the block is idle; the
// block does not enforce it. Reset (rst, synchronous) empties both registers,
// restores the power-up banking (fixed-last program mode, horizontal
// mirroring) and the default counts of 16 program banks and character RAM.
// When m_tready is low the result register holds and the input register still
// takes one more word; s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_bank_switch_mapper_core (
  input  logic                               clk,
  input  logic                               rst,
  // fields: bus_address[15:0], write_data[23:16]
  input  logic [sbsm_pkg::S_TDATA_W-1:0]     s_tdata,
  // fields: func[1:0]
  input  logic [1:0]                         s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // fields: mapped_address[17:0], mirroring[19:18], zero pad[23:20]
  output logic [sbsm_pkg::M_TDATA_W-1:0]     m_tdata,
  // fields: handled[0]
  output logic                               m_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [sbsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sbsm_pkg::*;

  logic       in_valid, in_valid_next;
  access_t    in_word;
  logic       out_valid, out_valid_next;
  result_t    out_word;
  result_t    xl_result;
  logic       s_fire;
  logic       advance;
  logic [4:0] prog_count;
  logic [5:0] char_count;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  assign in_valid_next  = s_fire || (in_valid && !advance);
  assign out_valid_next = advance || (out_valid && !m_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_count <= PROG_COUNT_RESET;
      char_count <= CHAR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROG_COUNT: prog_count <= cfg_data[4:0];
        CFG_CHAR_COUNT: char_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_word.func        <= func_t'(s_tuser);
      in_word.bus_address <= s_tdata[ADDR_W-1:0];
      in_word.write_data  <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  sbsm_xlate u_xlate (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .access     (in_word),
    .prog_count (prog_count),
    .char_count (char_count),
    .result     (xl_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= xl_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_word.handled;
  assign m_tdata  = {{(M_TDATA_W-MAP_W-MIR_W){1'b0}}, out_word.mirroring,
                     out_word.mapped_address};

  `ASSERT_IMPLY(a_unhandled_zero, clk, rst, out_valid && !m_tuser, m_tdata[MAP_W-1:0] == '0)
  `ASSERT_NEXT(a_word_moves_on, clk, rst, advance, out_valid)
  `ASSERT_NEXT(a_stall_keeps_input, clk, rst, in_valid && out_valid && !m_tready, in_valid)

endmodule

// ----- sim/serial_bank_switch_mapper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core_test
// Drives bus accesses into the mapper and checks every result word against a
// cycle-free model of the banking logic: serial register loads, register
// commits, program and character translation and mirroring. Bank counts are
// rewritten between bursts while the pipeline is empty, and both stream sides
// stall at random in the first two of three idling regimes.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_core_test;
  import sbsm_pkg::*;

  // Model of the mapper registers; holds one expected word per access
  class mapper_scoreboard;
    logic [4:0]  prog_count;
    logic [5:0]  char_count;
    logic [4:0]  shift_value;
    logic [2:0]  shift_count;
    logic [4:0]  control;
    logic [4:0]  char_low;
    logic [4:0]  char_high;
    logic [4:0]  char_pair;
    logic [3:0]  prog_half;
    logic [2:0]  prog_full;
    logic [1:0]  mirror;
    result_t     expected_words[$];
    int          fails;

    function new();
      prog_count  = PROG_COUNT_RESET;
      char_count  = CHAR_COUNT_RESET;
      shift_value = '0;
      shift_count = '0;
      control     = CONTROL_RESET;
      char_low    = '0;
      char_high   = '0;
      char_pair   = '0;
      prog_half   = '0;
      prog_full   = '0;
      mirror      = MIRROR_RESET;
      fails       = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Update the banking state for one accepted access and queue its result
    function void note_access(access_t acc);
      result_t     exp;
      logic [15:0] a;
      logic [1:0]  mode;
      logic        four_k;
      logic [4:0]  loaded;
      logic [3:0]  last_bank;
      a         = acc.bus_address;
      mode      = control[3:2];
      four_k    = control[4];
      last_bank = 4'(prog_count - 5'd1);
      exp.handled        = 1'b0;
      exp.mapped_address = '0;
      case (acc.func)
        FUNC_CPU_RD: begin
          if (a[15]) begin
            exp.handled = 1'b1;
            if (mode < MODE_FIXED_FIRST)
              exp.mapped_address = {prog_full, a[14:0]};
            else if (mode == MODE_FIXED_FIRST)
              exp.mapped_address = a[14] ? {prog_half, a[13:0]} : {4'd0, a[13:0]};
            else
              exp.mapped_address = a[14] ? {last_bank, a[13:0]} : {prog_half, a[13:0]};
          end
        end
        FUNC_CPU_WR: begin
          if (a[15]) begin
            exp.handled = 1'b1;
            if (acc.write_data[7]) begin
              // Reset write: clear the shifter, force fixed-last program mode
              shift_value = '0;
              shift_count = '0;
              control     = control | CONTROL_PROG_FIX;
            end else begin
              loaded = {acc.write_data[0], shift_value[4:1]};
              if (shift_count == SHIFT_LAST) begin
                // Fifth bit: commit to the register picked by address 14:13
                case (a[14:13])
                  TGT_CONTROL: begin
                    control = loaded;
                    mirror  = loaded[1:0];
                  end
                  TGT_CHAR_LOW: begin
                    if (four_k) char_low = loaded;
                    else        char_pair = {loaded[4:1], 1'b0};
                  end
                  TGT_CHAR_HIGH: begin
                    if (four_k) char_high = loaded;
                  end
                  default: begin
                    if (mode < MODE_FIXED_FIRST) prog_full = loaded[3:1];
                    else                         prog_half = loaded[3:0];
                  end
                endcase
                shift_value = '0;
                shift_count = '0;
              end else begin
                shift_value = loaded;
                shift_count = shift_count + 3'd1;
              end
            end
          end
        end
        FUNC_PIC_RD: begin
          if (a[15:13] == 3'd0) begin
            exp.handled = 1'b1;
            if (char_count == 6'd0)
              exp.mapped_address = 18'(a);
            else if (four_k)
              exp.mapped_address = {1'b0, (a[12] ? char_high : char_low), a[11:0]};
            else
              exp.mapped_address = (18'(char_pair) << 12) + 18'(a[12:0]);
          end
        end
        default: begin
          // Picture writes only reach character RAM
          if (a[15:13] == 3'd0 && char_count == 6'd0) begin
            exp.handled        = 1'b1;
            exp.mapped_address = 18'(a);
          end
        end
      endcase
      exp.mirroring = mirror;
      expected_words.push_back(exp);
    endfunction

    // Compare one output word with the oldest expectation
    function void check_result(logic handled, logic [MAP_W-1:0] mapped,
                               logic [MIR_W-1:0] mirroring);
      result_t exp;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: handled %0d mapped_address 0x%0h mirroring %0d",
               handled, mapped, mirroring);
        fails++;
        return;
      end
      exp = expected_words.pop_front();
      if (handled !== exp.handled) begin
        $error("handled: expected %0d, got %0d", exp.handled, handled);
        fails++;
      end
      if (mapped !== exp.mapped_address) begin
        $error("mapped_address: expected 0x%0h, got 0x%0h", exp.mapped_address, mapped);
        fails++;
      end
      if (mirroring !== exp.mirroring) begin
        $error("mirroring: expected %0d, got %0d", exp.mirroring, mirroring);
        fails++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mapper_scoreboard sb;
  int sent_count;
  int src_idle_pct;
  int sink_idle_pct;

  // Bank count settings, three per idling regime; extremes included
  int prog_setting [9] = '{1, 16, 0, 31, 8, 17, 2, 16, 1};
  int char_setting [9] = '{32, 0, 63, 1, 0, 32, 5, 63, 0};

  serial_bank_switch_mapper_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Take result words and toggle backpressure
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[MAP_W-1:0], m_tdata[MAP_W+MIR_W-1:MAP_W]);
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Offer one access word, idling first at random, and hold until taken
  task automatic send_access(input func_t f, input logic [15:0] a, input logic [7:0] d);
    access_t acc;
    acc.func        = f;
    acc.bus_address = a;
    acc.write_data  = d;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {d, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_access(acc);
    sent_count++;
  endtask

  // Stop sending and wait for every outstanding result word
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_counts(input logic [4:0] prog_cnt, input logic [5:0] char_cnt);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROG_COUNT;
    cfg_data  <= {1'b0, prog_cnt};
    @(posedge clk);
    cfg_index <= CFG_CHAR_COUNT;
    cfg_data  <= char_cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.prog_count = prog_cnt;
    sb.char_count = char_cnt;
  endtask

  // One access with the address mostly inside the range its bus decodes
  task automatic random_access(input bit allow_write);
    func_t       f;
    logic [15:0] a;
    f = func_t'($urandom_range(3));
    if (!allow_write && f == FUNC_CPU_WR) f = FUNC_CPU_RD;
    if ($urandom_range(99) < 25)
      a = 16'($urandom);
    else if (f == FUNC_CPU_RD || f == FUNC_CPU_WR)
      a = {1'b1, 15'($urandom)};
    else
      a = {3'b000, 13'($urandom)};
    send_access(f, a, 8'($urandom));
  endtask

  // Five serial writes, LSB first; only the last address picks the target
  task automatic load_serial(input logic [15:0] a, input logic [4:0] value,
                             input bit mix_reads);
    logic [15:0] wa;
    int i;
    for (i = 0; i < 5; i++) begin
      if (mix_reads && $urandom_range(99) < 15) random_access(1'b0);
      wa = (i == 4) ? a : {1'b1, 15'($urandom)};
      send_access(FUNC_CPU_WR, wa, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  // Run ends here if the block hangs
  initial begin
    #5_000_000;
    $display("serial_bank_switch_mapper_core_test: FAIL");
    $finish;
  end

  initial begin
    int ph;
    int j;
    int k;
    int target;
    int pick;
    sb            = new();
    sent_count    = 0;
    src_idle_pct  = 27;
    sink_idle_pct = 81;
    rst       = 1'b1;
    clk       = 1'b0;
    s_tdata   = '0;
    s_tuser   = FUNC_CPU_RD;
    s_tvalid  = 1'b0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PROG_COUNT;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: decode edges, power-up banking, reset write, full commits
    send_access(FUNC_CPU_RD, 16'hFFFF, 8'hFF);
    send_access(FUNC_CPU_RD, 16'h7FFF, 8'h00);
    send_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF);
    send_access(FUNC_PIC_RD, 16'h1FFF, 8'h00);
    send_access(FUNC_PIC_RD, 16'h2000, 8'h00);
    send_access(FUNC_PIC_WR, 16'h1FFF, 8'h00);
    send_access(FUNC_PIC_WR, 16'hFFFF, 8'h00);
    send_access(FUNC_CPU_WR, 16'h8000, 8'h80);
    load_serial(16'h8000, 5'h12, 1'b0);
    load_serial(16'hE000, 5'h1F, 1'b0);
    send_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
    // Character ROM: banked reads, picture writes refused
    write_counts(5'd4, 6'd32);
    send_access(FUNC_PIC_RD, 16'h0FFF, 8'h00);
    send_access(FUNC_PIC_WR, 16'h0000, 8'h00);
    // Partial load broken by a reset write
    send_access(FUNC_CPU_WR, 16'hC000, 8'h01);
    send_access(FUNC_CPU_WR, 16'hFFFF, 8'hFF);
    send_access(FUNC_CPU_RD, 16'hC000, 8'h00);

    // Random: three idling regimes, three bank count settings each
    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 27 : (ph == 1) ? 81 : 0;
      sink_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 27 : 0;
      for (j = 0; j < 3; j++) begin
        write_counts(5'(prog_setting[ph*3+j]), 6'(char_setting[ph*3+j]));
        target = sent_count + 106;
        while (sent_count < target) begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            load_serial({1'b1, 15'($urandom)}, 5'($urandom), 1'b1);
          end else if (pick < 48) begin
            // Broken load: a few bits, then a reset write
            for (k = $urandom_range(1, 4); k > 0; k--)
              send_access(FUNC_CPU_WR, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
            send_access(FUNC_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
          end else begin
            random_access(1'b1);
          end
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("serial_bank_switch_mapper_core_test: PASS");
    end else begin
      $display("serial_bank_switch_mapper_core_test: FAIL");
    end
    $finish;
  end

endmodule
